@@ design/sorted_symbol_count_list_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted symbol count list
// Clocked on clk and switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef SORTED_SYMBOL_COUNT_LIST_MACROS_SVH
`define SORTED_SYMBOL_COUNT_LIST_MACROS_SVH

// Same-cycle implication.
`define SSCL_ASSERT_IMPLY(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define SSCL_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

@@ design/sscl_pkg.sv @@
// ----------------------------------------------------------------------------
// sscl_pkg
// Types and constants shared by the sorted symbol count list and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sscl_pkg;

  localparam int CAPACITY  = 256;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int RANK_W    = 8;
  localparam int CMP_W     = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int ENTRIES_W = 9;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_READ   = 2'd2
  } lane_op_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [7:0]        symbol;
    logic [31:0]       occurrences;
    logic [RANK_W-1:0] rank;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [7:0]           read_symbol;
    logic [31:0]          read_occurrences;
    logic [ENTRIES_W-1:0] entries;
  } rsp_t;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic             valid;
    lane_op_t         op;
    logic             sorted;  // compare counts on the way (sorted insert)
    logic             found;   // insert point passed, shift the rest down
    logic             done;    // work finished, pass through untouched
    logic [CNT_W-1:0] target;  // tail position for insert, rank for read
    logic [7:0]       symbol;
    logic [31:0]      occurrences;
  } lane_t;

endpackage

`default_nettype wire

@@ design/sscl_cell.sv @@
// ----------------------------------------------------------------------------
// sscl_cell
// One table entry plus one stage of the travelling lane token.
// ----------------------------------------------------------------------------
`default_nettype none

module sscl_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [sscl_pkg::IDX_W-1:0] index,
  input  wire sscl_pkg::lane_t          lane_in,
  output sscl_pkg::lane_t               lane_out
);

  logic [7:0]      sym;
  logic [31:0]     occ;
  logic [7:0]      sym_next;
  logic [31:0]     occ_next;
  sscl_pkg::lane_t lane_next;
  logic            at_target;
  logic            live;

  assign at_target = (sscl_pkg::CNT_W'(index) == lane_in.target);
  assign live      = lane_in.valid && !lane_in.done;

  always_comb begin
    lane_next = lane_in;
    sym_next  = sym;
    occ_next  = occ;
    case (lane_in.op)
      sscl_pkg::OP_INSERT: begin
        // Swap in at the insert point and ripple the displaced pair to the tail.
        if (live && (at_target || lane_in.found ||
                     (lane_in.sorted && (occ <= lane_in.occurrences)))) begin
          sym_next              = lane_in.symbol;
          occ_next              = lane_in.occurrences;
          lane_next.symbol      = sym;
          lane_next.occurrences = occ;
          lane_next.found       = 1'b1;
          lane_next.done        = at_target;
        end
      end
      sscl_pkg::OP_READ: begin
        if (live && at_target) begin
          lane_next.symbol      = sym;
          lane_next.occurrences = occ;
          lane_next.done        = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else begin
      lane_out <= lane_next;
    end
  end

  always_ff @(posedge clk) begin
    sym <= sym_next;
    occ <= occ_next;
  end

endmodule

`default_nettype wire

@@ design/sscl_chain.sv @@
// ----------------------------------------------------------------------------
// sscl_chain
// Row of table cells; the lane token enters at the head and leaves at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module sscl_chain (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sscl_pkg::lane_t head,
  output sscl_pkg::lane_t      tail
);

  sscl_pkg::lane_t lane [sscl_pkg::CAPACITY];

  for (genvar i = 0; i < sscl_pkg::CAPACITY; i++) begin : g_cell
    sscl_pkg::lane_t feed;
    if (i == 0) begin : g_head
      assign feed = head;
    end else begin : g_body
      assign feed = lane[i-1];
    end
    sscl_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .index    (sscl_pkg::IDX_W'(i)),
      .lane_in  (feed),
      .lane_out (lane[i])
    );
  end

  assign tail = lane[sscl_pkg::CAPACITY-1];

endmodule

`default_nettype wire

@@ design/sorted_symbol_count_list.sv @@
// ----------------------------------------------------------------------------
// sorted_symbol_count_list
// Table of (symbol, count) pairs; a sorted insert keeps descending count order.
// ----------------------------------------------------------------------------
// Use: a command (sorted insert, append, read at rank, clear) is offered on
// req with req_valid and taken at a clock edge where req_stall is low. Each
// command gives exactly one result on rsp, held with rsp_valid until a clock
// edge where rsp_stall is low. Every result carries the entry count after the
// command; a read also carries the pair found at its rank.
// The command token walks the row of cells one cell per clock, and the result
// is registered from the token as it leaves the last cell. One command is in
// flight at a time: req_stall stays high from the transfer of a command to the
// transfer of its result.
// Reset empties the table (entry count zero) and drops any command in flight.
// A stalled result simply holds, and no new command is taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_symbol_count_list_macros.svh"

module sorted_symbol_count_list (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire sscl_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output sscl_pkg::rsp_t      rsp
);

  logic [sscl_pkg::CNT_W-1:0] total;
  logic [sscl_pkg::CNT_W-1:0] total_next;
  logic                       busy;
  logic [1:0]                 status_hold;
  logic [1:0]                 status_next;
  logic                       accept;
  logic                       done;
  logic                       full;
  sscl_pkg::lane_t            head;
  sscl_pkg::lane_t            tail;

  assign req_stall = busy;
  assign accept    = req_valid && !busy;
  assign done      = rsp_valid && !rsp_stall;
  assign full      = (total == sscl_pkg::CNT_W'(sscl_pkg::CAPACITY));

  always_comb begin
    total_next       = total;
    status_next      = sscl_pkg::ST_OK;
    head.valid       = accept;
    head.op          = sscl_pkg::OP_NONE;
    head.sorted      = (req.command == sscl_pkg::CMD_INSERT);
    head.found       = 1'b0;
    head.done        = 1'b0;
    head.target      = total;
    head.symbol      = req.symbol;
    head.occurrences = req.occurrences;
    case (req.command)
      sscl_pkg::CMD_INSERT, sscl_pkg::CMD_APPEND: begin
        if (full) begin
          status_next = sscl_pkg::ST_FULL;
        end else begin
          head.op    = sscl_pkg::OP_INSERT;
          total_next = total + sscl_pkg::CNT_W'(1);
        end
      end
      sscl_pkg::CMD_READ: begin
        if (sscl_pkg::CMP_W'(req.rank) < sscl_pkg::CMP_W'(total)) begin
          head.op     = sscl_pkg::OP_READ;
          head.target = sscl_pkg::CNT_W'(req.rank);
        end else begin
          status_next = sscl_pkg::ST_RANGE;
        end
      end
      sscl_pkg::CMD_CLEAR: begin
        total_next = '0;
      end
      default: begin
      end
    endcase
  end

  sscl_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .tail (tail)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      busy      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        total <= total_next;
        busy  <= 1'b1;
      end else if (done) begin
        busy <= 1'b0;
      end
      if (tail.valid) begin
        rsp_valid <= 1'b1;
      end else if (done) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Status and entry count are settled at the transfer; hold them for the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_hold <= status_next;
      rsp.entries <= sscl_pkg::ENTRIES_W'(total_next);
    end
    if (tail.valid) begin
      rsp.status <= status_hold;
      if (tail.op == sscl_pkg::OP_READ) begin
        rsp.read_symbol      <= tail.symbol;
        rsp.read_occurrences <= tail.occurrences;
      end else begin
        rsp.read_symbol      <= '0;
        rsp.read_occurrences <= '0;
      end
    end
  end

  `SSCL_ASSERT_IMPLY(a_total_bound, 1'b1, total <= sscl_pkg::CNT_W'(sscl_pkg::CAPACITY), "entry count above capacity")
  `SSCL_ASSERT_IMPLY(a_rsp_needs_busy, rsp_valid, busy, "result shown with no command in flight")
  `SSCL_ASSERT_IMPLY(a_tail_slot_free, tail.valid, busy && !rsp_valid, "token left chain while result slot occupied")
  `SSCL_ASSERT_NEXT(a_no_early_rsp, accept, !rsp_valid && !tail.valid, "result too soon after command transfer")
  `SSCL_ASSERT_IMPLY(a_full_count, rsp_valid && (rsp.status == sscl_pkg::ST_FULL), total == sscl_pkg::CNT_W'(sscl_pkg::CAPACITY), "full status with room in table")

endmodule

`default_nettype wire
